FILE: src/grc_pkg.sv
package grc_pkg;

	// Shared divider operand widths.
	localparam int DIV_W = 48;
	localparam int DVS_W = 34;

	localparam logic [7:0] COST_FULL = 8'd254;

	localparam logic [1:0] ST_WRITE   = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_NOMAP   = 2'd2;

	localparam logic [2:0] REG_CENTER_X  = 3'd0;
	localparam logic [2:0] REG_CENTER_Y  = 3'd1;
	localparam logic [2:0] REG_CELL_SIZE = 3'd2;
	localparam logic [2:0] REG_COST_CELL = 3'd3;
	localparam logic [2:0] REG_COLS      = 3'd4;
	localparam logic [2:0] REG_ROWS      = 3'd5;
	localparam logic [2:0] REG_VAL_LOW   = 3'd6;
	localparam logic [2:0] REG_VAL_HIGH  = 3'd7;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_CHECK, S_GEO, S_DIVW, S_PK, S_PL,
		S_ADDR, S_READ, S_DATA, S_INT1, S_INT2, S_NORM, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		TG_BCOL, TG_BFX, TG_BROW, TG_BFY, TG_NCOL, TG_NROW,
		TG_PCOL, TG_PROW, TG_NORM
	} tag_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: src/grc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  grc_pkg::div_req_t  req,
	output grc_pkg::div_rsp_t  rsp
);
	localparam int CW = $clog2(grc_pkg::DIV_W + 1);

	logic [grc_pkg::DIV_W-1:0] a_q;
	logic [grc_pkg::DVS_W-1:0] b_q;
	logic [grc_pkg::DVS_W-1:0] r_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [grc_pkg::DVS_W:0]   trial;
	logic [grc_pkg::DVS_W:0]   diff;
	logic                      fit;

	always_comb begin
		trial = {r_q, a_q[grc_pkg::DIV_W-1]};
		diff  = trial - {1'b0, b_q};
		fit   = (trial >= {1'b0, b_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(grc_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.dividend;
			b_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[grc_pkg::DIV_W-2:0], fit};
			r_q <= fit ? diff[grc_pkg::DVS_W-1:0] : trial[grc_pkg::DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = a_q;
	assign rsp.rem  = r_q;

endmodule

FILE: src/grc_store.sv
// Sample memory: one write port, one read port with registered data.
module grc_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/grid_resample_to_cost_top.sv
// Start and load transactions complete on acceptance; a query runs the sequencer until its result is taken.
// Queries share one divider: bilinear sampling uses up to five divisions and four memory
// reads, nearest up to three divisions and one read. Pooling uses one division per column
// step on the grid and one division and one read per sampled cell, with up to
// MAX_POOL_STEPS column steps of up to MAX_POOL_STEPS cells each, plus normalization.
// Reset clears the sequencer and the load count and sets the configuration defaults; no memory clear.
module grid_resample_to_cost_top #(
	parameter int MAX_CELLS      = 65536,
	parameter int MAX_POOL_STEPS = 16,
	parameter int NEAREST_MODE   = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] sample_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic [7:0]         existing_cost,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         cost,
	output logic [1:0]         status
);
	localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int LCW = $clog2(MAX_CELLS + 1);
	localparam int KW  = $clog2(MAX_POOL_STEPS + 1);
	localparam int KRW = 16 + KW;
	localparam int DW  = grc_pkg::DIV_W;
	localparam int VW  = grc_pkg::DVS_W;

	// Linear blend a + (b - a) * w / 65536, floored.
	function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [15:0] w);
		logic signed [32:0] d;
		logic signed [49:0] p;
		d = 33'(b) - 33'(a);
		p = 50'(d) * $signed({34'd0, w});
		return 32'(50'(a) + (p >>> 16));
	endfunction

	function automatic logic [16:0] clampi(input logic [DW-1:0] q, input logic [16:0] last);
		return (q > DW'(last)) ? last : q[16:0];
	endfunction

	function automatic logic [7:0] maxc(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a : b;
	endfunction

	// Configuration registers and values derived from them.
	logic signed [31:0] cx_q, cy_q, low_q, high_q;
	logic [15:0]        res_q, ccs_q;
	logic [16:0]        cols_q, rows_q;
	logic [32:0]        spanx_q, spany_q;
	logic [33:0]        area_q;

	grc_pkg::state_t state_q, state_n;
	grc_pkg::tag_t   tag_q;
	logic [LCW-1:0]  lc_q;

	// Query working registers.
	logic signed [31:0] qx_q, qy_q;
	logic [7:0]         ex_q;
	logic signed [39:0] bx_q, by_q;
	logic [16:0]        c0_q, c1_q, r0_q, r1_q;
	logic [15:0]        wx_q, wy_q;
	logic [1:0]         idx_q;
	logic signed [31:0] s_q [4];
	logic signed [31:0] top_q, bot_q, val_q;
	logic               have_q;
	logic [KW-1:0]      k_q, l_q;
	logic [KRW-1:0]     kres_q, lres_q;
	logic [AW-1:0]      raddr_q;
	logic [7:0]         cost_q;
	logic [1:0]         status_q;

	grc_pkg::div_req_t dreq;
	grc_pkg::div_rsp_t drsp;
	logic              st_we;
	logic [31:0]       rdata;

	logic               in_acc, pool, invalid, gin, k_act, l_act, pin_x, pin_y;
	logic               nonpos, full;
	logic [16:0]        two, lastc, lastr, rowsel, colsel;
	logic signed [32:0] dx, dy;
	logic signed [39:0] bx_n, by_n, pnx, pny;
	logic signed [34:0] num_r, den_r, num_a, den_a;
	logic [AW-1:0]      addr_n;
	grc_pkg::op_t       op;

	assign op     = grc_pkg::op_t'(operation);
	assign in_acc = in_valid && in_ready;
	// Pooling applies when the cost cell is coarser than a source cell.
	assign pool   = (ccs_q > res_q);
	assign two    = {res_q, 1'b0};
	assign lastc  = cols_q - 17'd1;
	assign lastr  = rows_q - 17'd1;

	always_comb begin
		invalid = (cols_q == '0) || (rows_q == '0) || (res_q == '0)
			|| (area_q > 34'(MAX_CELLS)) || (34'(lc_q) != area_q) || (high_q == low_q);
		dx   = 33'(qx_q) - 33'(cx_q);
		dy   = 33'(qy_q) - 33'(cy_q);
		bx_n = $signed({7'd0, spanx_q}) - (40'(dx) <<< 1);
		by_n = $signed({7'd0, spany_q}) - (40'(dy) <<< 1);
		// Bilinear and nearest require the point itself to be on the grid.
		gin  = !bx_q[39] && (bx_q <= $signed({6'd0, spanx_q, 1'b0}))
			&& !by_q[39] && (by_q <= $signed({6'd0, spany_q, 1'b0}));
		// Pooled sample positions, offset by half a cost cell and k source cells.
		pnx  = bx_q + $signed({24'd0, ccs_q}) - $signed(40'({kres_q, 1'b0}));
		pny  = by_q + $signed({24'd0, ccs_q}) - $signed(40'({lres_q, 1'b0}));
		pin_x = !pnx[39] && (pnx <= $signed({6'd0, spanx_q, 1'b0}));
		pin_y = !pny[39] && (pny <= $signed({6'd0, spany_q, 1'b0}));
		k_act = (k_q != KW'(MAX_POOL_STEPS)) && (kres_q < KRW'(ccs_q));
		l_act = (l_q != KW'(MAX_POOL_STEPS)) && (lres_q < KRW'(ccs_q));
		// Normalization works on the absolute range.
		num_r = 35'(val_q) - 35'(low_q);
		den_r = 35'(high_q) - 35'(low_q);
		num_a = den_r[34] ? -num_r : num_r;
		den_a = den_r[34] ? -den_r : den_r;
		nonpos = num_a[34] || (num_a == '0);
		full   = (num_a >= den_a);
		rowsel = idx_q[1] ? r1_q : r0_q;
		colsel = idx_q[0] ? c1_q : c0_q;
		addr_n = AW'(34'(rowsel) * 34'(cols_q) + 34'(colsel));
	end

	// Next-state logic.
	always_comb begin
		state_n = state_q;
		case (state_q)
			grc_pkg::S_IDLE:  if (in_acc && op == grc_pkg::OP_QUERY) begin
				state_n = grc_pkg::S_PREP;
			end
			grc_pkg::S_PREP:  state_n = grc_pkg::S_CHECK;
			grc_pkg::S_CHECK: state_n = invalid ? grc_pkg::S_OUT : grc_pkg::S_GEO;
			grc_pkg::S_GEO: begin
				if (pool) begin
					state_n = grc_pkg::S_PK;
				end else begin
					state_n = gin ? grc_pkg::S_DIVW : grc_pkg::S_OUT;
				end
			end
			grc_pkg::S_DIVW: if (drsp.done) begin
				case (tag_q)
					grc_pkg::TG_BFY, grc_pkg::TG_NROW, grc_pkg::TG_PROW: begin
						state_n = grc_pkg::S_ADDR;
					end
					grc_pkg::TG_PCOL: state_n = grc_pkg::S_PL;
					grc_pkg::TG_NORM: state_n = grc_pkg::S_OUT;
					default:          state_n = grc_pkg::S_DIVW;
				endcase
			end
			grc_pkg::S_PK: begin
				if (!k_act) begin
					state_n = grc_pkg::S_NORM;
				end else if (pin_x) begin
					state_n = grc_pkg::S_DIVW;
				end
			end
			grc_pkg::S_PL: begin
				if (!l_act) begin
					state_n = grc_pkg::S_PK;
				end else if (pin_y) begin
					state_n = grc_pkg::S_DIVW;
				end
			end
			grc_pkg::S_ADDR: state_n = grc_pkg::S_READ;
			grc_pkg::S_READ: state_n = grc_pkg::S_DATA;
			grc_pkg::S_DATA: begin
				if (pool) begin
					state_n = grc_pkg::S_PL;
				end else if (NEAREST_MODE != 0) begin
					state_n = grc_pkg::S_NORM;
				end else if (idx_q == 2'd3) begin
					state_n = grc_pkg::S_INT1;
				end else begin
					state_n = grc_pkg::S_ADDR;
				end
			end
			grc_pkg::S_INT1: state_n = grc_pkg::S_INT2;
			grc_pkg::S_INT2: state_n = grc_pkg::S_NORM;
			grc_pkg::S_NORM: begin
				state_n = (!have_q || nonpos || full) ? grc_pkg::S_OUT : grc_pkg::S_DIVW;
			end
			grc_pkg::S_OUT: if (out_ready) begin
				state_n = grc_pkg::S_IDLE;
			end
			default: state_n = grc_pkg::S_IDLE;
		endcase
	end

	// Output and divider request logic.
	always_comb begin
		in_ready      = (state_q == grc_pkg::S_IDLE);
		out_valid     = (state_q == grc_pkg::S_OUT);
		st_we         = in_acc && (op == grc_pkg::OP_LOAD) && (lc_q < LCW'(MAX_CELLS));
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = VW'(two);
		case (state_q)
			grc_pkg::S_GEO: if (!pool && gin) begin
				dreq.start    = 1'b1;
				dreq.dividend = (NEAREST_MODE != 0) ? DW'(bx_q[38:0] + 39'(res_q))
					: DW'(bx_q[38:0]);
			end
			grc_pkg::S_DIVW: if (drsp.done) begin
				case (tag_q)
					grc_pkg::TG_BCOL, grc_pkg::TG_BROW: begin
						dreq.start    = 1'b1;
						dreq.dividend = DW'({drsp.rem, 16'd0});
					end
					grc_pkg::TG_BFX: begin
						dreq.start    = 1'b1;
						dreq.dividend = DW'(by_q[38:0]);
					end
					grc_pkg::TG_NCOL: begin
						dreq.start    = 1'b1;
						dreq.dividend = DW'(by_q[38:0] + 39'(res_q));
					end
					default: dreq.start = 1'b0;
				endcase
			end
			grc_pkg::S_PK: if (k_act && pin_x) begin
				dreq.start    = 1'b1;
				dreq.dividend = DW'(pnx[38:0] + 39'(res_q));
			end
			grc_pkg::S_PL: if (l_act && pin_y) begin
				dreq.start    = 1'b1;
				dreq.dividend = DW'(pny[38:0] + 39'(res_q));
			end
			grc_pkg::S_NORM: if (have_q && !nonpos && !full) begin
				// num * 254 as a shift and subtract.
				dreq.start    = 1'b1;
				dreq.dividend = (DW'(num_a[33:0]) << 8) - (DW'(num_a[33:0]) << 1);
				dreq.divisor  = den_a[33:0];
			end
			default: dreq.start = 1'b0;
		endcase
		cost   = cost_q;
		status = status_q;
	end

	// Control state: sequencer, division tag, load count and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::S_IDLE;
			tag_q   <= grc_pkg::TG_BCOL;
			lc_q    <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			res_q   <= 16'd410;
			ccs_q   <= 16'd205;
			cols_q  <= 17'd1;
			rows_q  <= 17'd1;
			low_q   <= '0;
			high_q  <= 32'sd65536;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_index)
					grc_pkg::REG_CENTER_X:  cx_q   <= cfg_data;
					grc_pkg::REG_CENTER_Y:  cy_q   <= cfg_data;
					grc_pkg::REG_CELL_SIZE: res_q  <= cfg_data[15:0];
					grc_pkg::REG_COST_CELL: ccs_q  <= cfg_data[15:0];
					grc_pkg::REG_COLS:      cols_q <= cfg_data[16:0];
					grc_pkg::REG_ROWS:      rows_q <= cfg_data[16:0];
					grc_pkg::REG_VAL_LOW:   low_q  <= cfg_data;
					grc_pkg::REG_VAL_HIGH:  high_q <= cfg_data;
					default:                cx_q   <= cx_q;
				endcase
			end
			if (in_acc && op == grc_pkg::OP_START) begin
				lc_q <= '0;
			end else if (st_we) begin
				lc_q <= lc_q + LCW'(1);
			end
			case (state_q)
				grc_pkg::S_GEO: begin
					tag_q <= (NEAREST_MODE != 0) ? grc_pkg::TG_NCOL : grc_pkg::TG_BCOL;
				end
				grc_pkg::S_DIVW: if (drsp.done) begin
					case (tag_q)
						grc_pkg::TG_BCOL: tag_q <= grc_pkg::TG_BFX;
						grc_pkg::TG_BFX:  tag_q <= grc_pkg::TG_BROW;
						grc_pkg::TG_BROW: tag_q <= grc_pkg::TG_BFY;
						grc_pkg::TG_NCOL: tag_q <= grc_pkg::TG_NROW;
						default:          tag_q <= tag_q;
					endcase
				end
				grc_pkg::S_PK:   tag_q <= grc_pkg::TG_PCOL;
				grc_pkg::S_PL:   tag_q <= grc_pkg::TG_PROW;
				grc_pkg::S_NORM: tag_q <= grc_pkg::TG_NORM;
				default:         tag_q <= tag_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		spanx_q <= 33'((cols_q - 17'd1) * res_q);
		spany_q <= 33'((rows_q - 17'd1) * res_q);
		area_q  <= 34'(cols_q) * 34'(rows_q);
		case (state_q)
			grc_pkg::S_IDLE: begin
				qx_q <= query_x;
				qy_q <= query_y;
				ex_q <= existing_cost;
			end
			grc_pkg::S_CHECK: begin
				bx_q     <= bx_n;
				by_q     <= by_n;
				cost_q   <= ex_q;
				status_q <= grc_pkg::ST_NOMAP;
			end
			grc_pkg::S_GEO: begin
				k_q      <= '0;
				kres_q   <= '0;
				idx_q    <= '0;
				have_q   <= !pool;
				cost_q   <= ex_q;
				status_q <= grc_pkg::ST_OUTSIDE;
			end
			grc_pkg::S_DIVW: if (drsp.done) begin
				case (tag_q)
					grc_pkg::TG_BCOL: c0_q <= drsp.quot[16:0];
					grc_pkg::TG_BFX:  wx_q <= drsp.quot[15:0];
					grc_pkg::TG_BROW: r0_q <= drsp.quot[16:0];
					grc_pkg::TG_BFY: begin
						wy_q <= drsp.quot[15:0];
						c1_q <= (c0_q == lastc) ? lastc : c0_q + 17'd1;
						r1_q <= (r0_q == lastr) ? lastr : r0_q + 17'd1;
					end
					grc_pkg::TG_NCOL, grc_pkg::TG_PCOL: begin
						c0_q   <= clampi(drsp.quot, lastc);
						l_q    <= '0;
						lres_q <= '0;
					end
					grc_pkg::TG_NROW, grc_pkg::TG_PROW: r0_q <= clampi(drsp.quot, lastr);
					grc_pkg::TG_NORM: begin
						cost_q   <= maxc(drsp.quot[7:0], ex_q);
						status_q <= grc_pkg::ST_WRITE;
					end
					default: c0_q <= c0_q;
				endcase
			end
			grc_pkg::S_PK: if (k_act && !pin_x) begin
				k_q    <= k_q + KW'(1);
				kres_q <= kres_q + KRW'(res_q);
			end
			grc_pkg::S_PL: begin
				if (!l_act) begin
					k_q    <= k_q + KW'(1);
					kres_q <= kres_q + KRW'(res_q);
				end else if (!pin_y) begin
					l_q    <= l_q + KW'(1);
					lres_q <= lres_q + KRW'(res_q);
				end
			end
			grc_pkg::S_ADDR: raddr_q <= addr_n;
			grc_pkg::S_DATA: begin
				if (pool) begin
					if (!have_q || $signed(rdata) > val_q) begin
						val_q <= rdata;
					end
					have_q <= 1'b1;
					l_q    <= l_q + KW'(1);
					lres_q <= lres_q + KRW'(res_q);
				end else begin
					val_q      <= rdata;
					s_q[idx_q] <= rdata;
					idx_q      <= idx_q + 2'd1;
				end
			end
			grc_pkg::S_INT1: begin
				top_q <= lerp(s_q[0], s_q[1], wx_q);
				bot_q <= lerp(s_q[2], s_q[3], wx_q);
			end
			grc_pkg::S_INT2: val_q <= lerp(top_q, bot_q, wy_q);
			grc_pkg::S_NORM: begin
				status_q <= grc_pkg::ST_WRITE;
				cost_q   <= (have_q && !nonpos && full) ? maxc(grc_pkg::COST_FULL, ex_q) : ex_q;
			end
			default: cost_q <= cost_q;
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	grc_store #(
		.DEPTH (MAX_CELLS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (lc_q[AW-1:0]),
		.wdata (sample_value),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	// The block never takes a new transaction while a result is pending.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while result pending");

	// The load count never passes the store depth.
	a_lc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= LCW'(MAX_CELLS)) else $error("load count overflow");

	// A division completes only while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == grc_pkg::S_DIVW)) else $error("stray divider result");

	// A delivered result returns the block to idle.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("no return to idle");

endmodule
